/* rtl/core/hcr_pkg.sv */
// Package with widths, mixing constants and beat types of the hashed chance roll unit.
package hcr_pkg;

   localparam int TYPE_W   = 10;
   localparam int INST_W   = 32;
   localparam int ID_W     = 20;
   localparam int CHANCE_W = 20;
   localparam int SEED_W   = 32;
   localparam int KEY_W    = 64;
   localparam int HALF_W   = 32;
   localparam int DIGIT_W  = 20;

   localparam logic [HALF_W-1:0] ID_MUL_LO  = 32'h6659FD93;
   localparam logic [HALF_W-1:0] ID_MUL_HI  = 32'hD6E8FEB8;
   localparam logic [KEY_W-1:0]  GOLDEN_ADD = 64'h9E3779B97F4A7C15;
   localparam logic [HALF_W-1:0] MIX1_LO    = 32'h1CE4E5B9;
   localparam logic [HALF_W-1:0] MIX1_HI    = 32'hBF58476D;
   localparam logic [HALF_W-1:0] MIX2_LO    = 32'h133111EB;
   localparam logic [HALF_W-1:0] MIX2_HI    = 32'h94D049BB;

   localparam logic [DIGIT_W-1:0] ROLL_RANGE = 20'd1000000;
   localparam logic [15:0]        FOLD_P20   = 16'd48576;
   localparam logic [19:0]        FOLD_P40   = 20'd627776;
   localparam logic [19:0]        FOLD_P60   = 20'd846976;

   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    value;
      logic [CHANCE_W-1:0] chance;
   } hash_beat_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } roll_beat_type;

endpackage

/* rtl/core/hcr_if.sv */
// Valid/ready channel interfaces for request and response beats of the chance roll unit.
interface hcr_req_if;
   logic                          valid;
   logic                          ready;
   logic [hcr_pkg::TYPE_W-1:0]    type_code;
   logic [hcr_pkg::INST_W-1:0]    instance_number;
   logic [hcr_pkg::ID_W-1:0]      item_id;
   logic [hcr_pkg::CHANCE_W-1:0]  chance_fixed;

   modport source (output valid, type_code, instance_number, item_id, chance_fixed,
                   input ready);
   modport sink (input valid, type_code, instance_number, item_id, chance_fixed,
                 output ready);
endinterface

interface hcr_rsp_if;
   logic valid;
   logic ready;
   logic succeeds;

   modport source (output valid, succeeds, input ready);
   modport sink (input valid, succeeds, output ready);
endinterface

/* rtl/core/hcr_mix.sv */
// Seven-stage key builder and splitmix64 finaliser with multiplies split into 32-bit halves.
module hcr_mix (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [hcr_pkg::TYPE_W-1:0]    type_code,
   input  logic [hcr_pkg::INST_W-1:0]    instance_number,
   input  logic [hcr_pkg::ID_W-1:0]      item_id,
   input  logic [hcr_pkg::CHANCE_W-1:0]  chance_fixed,
   input  logic [hcr_pkg::SEED_W-1:0]    seed,
   output hcr_pkg::hash_beat_type        out
);

   localparam int STAGES = 7;
   localparam int KW = hcr_pkg::KEY_W;
   localparam int HW = hcr_pkg::HALF_W;
   localparam int PW = hcr_pkg::ID_W + HW;

   logic [STAGES-1:0]           vld_ff;
   logic [hcr_pkg::CHANCE_W-1:0] chance_ff [STAGES];

   logic [KW-1:0] base_in, base_ff;
   logic [PW-1:0] plo_in, plo_ff;
   logic [HW-1:0] phi_in, phi_ff;
   logic [KW-1:0] key_in, key_ff;
   logic [KW-1:0] sum3, x3_in, x3_ff;
   logic [KW-1:0] ll4_in, ll4_ff;
   logic [HW-1:0] lh4_in, lh4_ff, hl4_in, hl4_ff;
   logic [KW-1:0] y5, z5_in, z5_ff;
   logic [KW-1:0] ll6_in, ll6_ff;
   logic [HW-1:0] lh6_in, lh6_ff, hl6_in, hl6_ff;
   logic [KW-1:0] w7, v7_in, v7_ff;

   always_comb begin
      base_in = {{(KW-HW){1'b0}}, seed}
              ^ {{(KW-HW-hcr_pkg::TYPE_W){1'b0}}, type_code, {HW{1'b0}}}
              ^ {{(KW-hcr_pkg::INST_W){1'b0}}, instance_number};
      plo_in  = PW'(item_id) * PW'(hcr_pkg::ID_MUL_LO);
      phi_in  = HW'(item_id) * hcr_pkg::ID_MUL_HI;

      key_in  = base_ff ^ ({{(KW-PW){1'b0}}, plo_ff} + {phi_ff, {HW{1'b0}}});

      sum3    = key_ff + hcr_pkg::GOLDEN_ADD;
      x3_in   = sum3 ^ (sum3 >> 30);

      ll4_in  = KW'(x3_ff[HW-1:0]) * KW'(hcr_pkg::MIX1_LO);
      lh4_in  = x3_ff[HW-1:0] * hcr_pkg::MIX1_HI;
      hl4_in  = x3_ff[KW-1:HW] * hcr_pkg::MIX1_LO;

      y5      = ll4_ff + {lh4_ff + hl4_ff, {HW{1'b0}}};
      z5_in   = y5 ^ (y5 >> 27);

      ll6_in  = KW'(z5_ff[HW-1:0]) * KW'(hcr_pkg::MIX2_LO);
      lh6_in  = z5_ff[HW-1:0] * hcr_pkg::MIX2_HI;
      hl6_in  = z5_ff[KW-1:HW] * hcr_pkg::MIX2_LO;

      w7      = ll6_ff + {lh6_ff + hl6_ff, {HW{1'b0}}};
      v7_in   = w7 ^ (w7 >> 31);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         chance_ff[0] <= chance_fixed;
         for (int i = 1; i < STAGES; i++) begin
            chance_ff[i] <= chance_ff[i-1];
         end
         base_ff <= base_in;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         key_ff  <= key_in;
         x3_ff   <= x3_in;
         ll4_ff  <= ll4_in;
         lh4_ff  <= lh4_in;
         hl4_ff  <= hl4_in;
         z5_ff   <= z5_in;
         ll6_ff  <= ll6_in;
         lh6_ff  <= lh6_in;
         hl6_ff  <= hl6_in;
         v7_ff   <= v7_in;
      end
   end

   assign out.valid  = vld_ff[STAGES-1];
   assign out.value  = v7_ff;
   assign out.chance = chance_ff[STAGES-1];

endmodule

/* rtl/core/hcr_mod.sv */
// Eight stages: hash reduced modulo one million by 20-bit folding, then the chance compare.
module hcr_mod (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  hcr_pkg::hash_beat_type in,
   output hcr_pkg::roll_beat_type out
);

   localparam int STAGES = 8;
   localparam int DW = hcr_pkg::DIGIT_W;

   logic [STAGES-1:0]            vld_ff;
   logic [hcr_pkg::CHANCE_W-1:0] chance_ff [STAGES-1];

   logic [DW-1:0] d0_in, d0_ff;
   logic [35:0]   pa_in, pa_ff;
   logic [39:0]   pb_in, pb_ff;
   logic [23:0]   pc_in, pc_ff;
   logic [39:0]   s1_in, s1_ff;
   logic [35:0]   s2_in, s2_ff;
   logic [31:0]   s3_in, s3_ff;
   logic [26:0]   s4_in, s4_ff;
   logic [22:0]   s5_in, s5_ff;
   logic [20:0]   s6_in, s6_ff;
   logic [DW-1:0] roll;
   logic          hit_in, hit_ff;

   always_comb begin
      d0_in = in.value[19:0];
      pa_in = 36'(in.value[39:20]) * 36'(hcr_pkg::FOLD_P20);
      pb_in = 40'(in.value[59:40]) * 40'(hcr_pkg::FOLD_P40);
      pc_in = 24'(in.value[63:60]) * 24'(hcr_pkg::FOLD_P60);

      s1_in = 40'(d0_ff) + 40'(pa_ff) + pb_ff + 40'(pc_ff);
      s2_in = 36'(s1_ff[19:0]) + 36'(s1_ff[39:20]) * 36'(hcr_pkg::FOLD_P20);
      s3_in = 32'(s2_ff[19:0]) + 32'(s2_ff[35:20]) * 32'(hcr_pkg::FOLD_P20);
      s4_in = 27'(s3_ff[19:0]) + 27'(s3_ff[31:20]) * 27'(hcr_pkg::FOLD_P20);
      s5_in = 23'(s4_ff[19:0]) + 23'(s4_ff[26:20]) * 23'(hcr_pkg::FOLD_P20);
      s6_in = 21'(s5_ff[19:0]) + 21'(s5_ff[22:20]) * 21'(hcr_pkg::FOLD_P20);

      if (s6_ff >= 21'(hcr_pkg::ROLL_RANGE)) begin
         roll = DW'(s6_ff - 21'(hcr_pkg::ROLL_RANGE));
      end else begin
         roll = s6_ff[DW-1:0];
      end
      hit_in = roll < chance_ff[STAGES-2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         chance_ff[0] <= in.chance;
         for (int i = 1; i < STAGES-1; i++) begin
            chance_ff[i] <= chance_ff[i-1];
         end
         d0_ff  <= d0_in;
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         pc_ff  <= pc_in;
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         hit_ff <= hit_in;
      end
   end

   assign out.valid = vld_ff[STAGES-1];
   assign out.hit   = hit_ff;

endmodule

/* rtl/core/hashed_chance_roll_unit.sv */
// Top level of the hashed chance roll unit: seed register, hash and modulo pipelines, output skid.
//
// Each request beat carries a type code, an instance number, an item id and a chance in
// units of one ten-thousandth of a percent. The unit hashes a 64-bit key built from these
// and the seed with the splitmix64 finaliser, reduces it modulo one million and returns
// one response beat whose succeeds bit is set when that roll lies below the chance.
// A chance of zero never succeeds and one of a million or more always does.
// The seed is written through csr_wr_en and csr_wr_data; the user must do so only while
// no roll is in flight; the unit does not enforce this. The pipeline has fifteen register
// stages and an output register; one request is taken every cycle while req.ready is high.
// When the receiver stalls, the response waiting in the output register holds and the
// next one drops into a skid register; req.ready then falls and the whole pipeline
// freezes until the skid register drains, so no beat is lost or repeated.
// Synchronous reset clears all valid bits, empties both output registers and sets the
// seed to zero; the unit takes requests from the first cycle after reset.
module hashed_chance_roll_unit (
   input  logic                        clock,
   input  logic                        reset,
   hcr_req_if.sink                     req,
   hcr_rsp_if.source                   rsp,
   input  logic                        csr_wr_en,
   input  logic [hcr_pkg::SEED_W-1:0]  csr_wr_data
);

   logic [hcr_pkg::SEED_W-1:0] seed_ff;
   logic                       en;
   hcr_pkg::hash_beat_type     hash_beat;
   hcr_pkg::roll_beat_type     roll_beat;

   logic out_vld_ff, out_hit_ff;
   logic skid_vld_ff, skid_hit_ff;
   logic out_free;

   assign en       = !skid_vld_ff;
   assign out_free = !out_vld_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   hcr_mix u_mix (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req.valid),
      .type_code       (req.type_code),
      .instance_number (req.instance_number),
      .item_id         (req.item_id),
      .chance_fixed    (req.chance_fixed),
      .seed            (seed_ff),
      .out             (hash_beat)
   );

   hcr_mod u_mod (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in    (hash_beat),
      .out   (roll_beat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (out_free) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (out_free) begin
         out_vld_ff <= roll_beat.valid;
      end else if (roll_beat.valid) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_free) begin
            out_hit_ff <= skid_hit_ff;
         end
      end else if (out_free) begin
         out_hit_ff <= roll_beat.hit;
      end else begin
         skid_hit_ff <= roll_beat.hit;
      end
   end

   assign req.ready    = en;
   assign rsp.valid    = out_vld_ff;
   assign rsp.succeeds = out_hit_ff;

endmodule

/* verif/tb_hashed_chance_roll_unit.sv */
// Self-checking testbench for the hashed chance roll unit, with random idling on both channels.
`timescale 1ns / 1ps

module tb_hashed_chance_roll_unit;

   localparam logic [63:0] ID_MULT       = 64'hD6E8FEB86659FD93;
   localparam logic [63:0] GOLDEN_GAMMA  = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MULT_A    = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MULT_B    = 64'h94D049BB133111EB;
   localparam logic [63:0] ROLL_SPAN     = 64'd1000000;
   localparam int          RANDOM_ROLLS  = 107;
   localparam int          DRAIN_CYCLES  = 40;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [hcr_pkg::TYPE_W-1:0]   type_code;
      logic [hcr_pkg::INST_W-1:0]   instance_number;
      logic [hcr_pkg::ID_W-1:0]     item_id;
      logic [hcr_pkg::CHANCE_W-1:0] chance_fixed;
   } roll_request_type;

   logic                        clock;
   logic                        reset;
   logic                        csr_wr_en;
   logic [hcr_pkg::SEED_W-1:0]  csr_wr_data;

   hcr_req_if req_ch ();
   hcr_rsp_if rsp_ch ();

   roll_request_type            pending_rolls[$];
   bit                          expected_hits[$];
   roll_request_type            driven_roll;
   logic [hcr_pkg::SEED_W-1:0]  model_seed;
   bit                          in_flight;
   bit                          send_burst;
   bit                          recv_burst;
   int                          send_gap;
   int                          hold_left;
   int                          stall_cycles;
   int                          mismatches;
   bit                          expected_hit;

   hashed_chance_roll_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit roll_succeeds(input logic [hcr_pkg::SEED_W-1:0] seed,
                                        input roll_request_type r);
      logic [63:0] key;
      logic [63:0] mixed;
      if (r.chance_fixed == '0)
         return 1'b0;
      if (r.chance_fixed >= 20'd1000000)
         return 1'b1;
      key = {32'd0, seed} ^ {22'd0, r.type_code, 32'd0} ^ {32'd0, r.instance_number}
            ^ ({44'd0, r.item_id} * ID_MULT);
      mixed = key + GOLDEN_GAMMA;
      mixed = (mixed ^ (mixed >> 30)) * MIX_MULT_A;
      mixed = (mixed ^ (mixed >> 27)) * MIX_MULT_B;
      mixed = mixed ^ (mixed >> 31);
      return (mixed % ROLL_SPAN) < {44'd0, r.chance_fixed};
   endfunction

   function automatic roll_request_type random_roll();
      roll_request_type r;
      int               pick;
      r.type_code = 10'($urandom_range(0, 1023));
      pick = $urandom_range(0, 9);
      if (pick == 0)
         r.instance_number = 32'h0;
      else if (pick == 1)
         r.instance_number = 32'hFFFFFFFF;
      else
         r.instance_number = $urandom;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         r.item_id = '0;
      else if (pick == 1)
         r.item_id = 20'($urandom_range(1000000, 1048575));
      else if (pick == 2)
         r.item_id = 20'd1;
      else
         r.item_id = 20'($urandom_range(1, 999999));
      pick = $urandom_range(0, 19);
      if (pick == 0)
         r.chance_fixed = '0;
      else if (pick == 1)
         r.chance_fixed = 20'd1000000;
      else if (pick == 2)
         r.chance_fixed = 20'($urandom_range(1000001, 1048575));
      else if (pick == 3)
         r.chance_fixed = 20'd1;
      else
         r.chance_fixed = 20'($urandom_range(1, 999999));
      return r;
   endfunction

   task automatic queue_roll(input logic [hcr_pkg::TYPE_W-1:0] type_code,
                             input logic [hcr_pkg::INST_W-1:0] instance_number,
                             input logic [hcr_pkg::ID_W-1:0] item_id,
                             input logic [hcr_pkg::CHANCE_W-1:0] chance_fixed);
      roll_request_type r;
      r.type_code       = type_code;
      r.instance_number = instance_number;
      r.item_id         = item_id;
      r.chance_fixed    = chance_fixed;
      pending_rolls = {pending_rolls, r};
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_rolls.size() != 0 || req_ch.valid || expected_hits.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_seed(input logic [hcr_pkg::SEED_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      model_seed = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_phase(input logic [hcr_pkg::SEED_W-1:0] seed);
      wait_idle();
      write_seed(seed);
      repeat (RANDOM_ROLLS) pending_rolls = {pending_rolls, random_roll()};
   endtask

   // Sender: one beat at a time; each beat draws a random gap that comes before the next beat.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_hits = {expected_hits, roll_succeeds(model_seed, driven_roll)};
            in_flight = 1'b0;
         end else begin
            in_flight = req_ch.valid;
         end
         if (!in_flight) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_rolls.size() != 0) begin
               driven_roll = pending_rolls.pop_front();
               req_ch.valid           <= 1'b1;
               req_ch.type_code       <= driven_roll.type_code;
               req_ch.instance_number <= driven_roll.instance_number;
               req_ch.item_id         <= driven_roll.item_id;
               req_ch.chance_fixed    <= driven_roll.chance_fixed;
               if ($urandom_range(0, 39) == 0)
                  send_burst = !send_burst;
               send_gap = send_burst ? 0 : $urandom_range(0, 4);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each response beat and draws a stall before taking the next one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_hits.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: response beat with no request outstanding, succeeds=%b",
                           $realtime, rsp_ch.succeeds);
               mismatches++;
            end else begin
               expected_hit = expected_hits.pop_front();
               if (rsp_ch.succeeds !== expected_hit) begin
                  if (mismatches < REPORT_LIMIT)
                     $display("%0t: succeeds mismatch, expected %b, actual %b",
                              $realtime, expected_hit, rsp_ch.succeeds);
                  mismatches++;
               end
            end
            if ($urandom_range(0, 39) == 0)
               recv_burst = !recv_burst;
            hold_left = recv_burst ? 0 : $urandom_range(0, 4);
         end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
         end
         rsp_ch.ready <= (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      model_seed   = '0;
      stall_cycles = 0;
      mismatches   = 0;
      send_burst   = 1'b0;
      recv_burst   = 1'b0;
      in_flight    = 1'b0;
      req_ch.valid           = 1'b0;
      req_ch.type_code       = '0;
      req_ch.instance_number = '0;
      req_ch.item_id         = '0;
      req_ch.chance_fixed    = '0;
      rsp_ch.ready           = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Edge values at the reset seed: zero and certain chances, ids outside 1 to 999999.
      queue_roll(10'd0,    32'h00000000, 20'd1,      20'd0);
      queue_roll(10'd1023, 32'hFFFFFFFF, 20'd999999, 20'd1000000);
      queue_roll(10'd5,    32'h0000007B, 20'd77,     20'hFFFFF);
      queue_roll(10'd0,    32'h00000000, 20'd0,      20'd500000);
      queue_roll(10'd1023, 32'hFFFFFFFF, 20'hFFFFF,  20'd999999);
      queue_roll(10'd0,    32'h00000000, 20'd1,      20'd1);
      queue_roll(10'd1023, 32'h00000000, 20'd999999, 20'd999999);
      queue_roll(10'd0,    32'hFFFFFFFF, 20'd1,      20'd500000);
      queue_roll(10'd512,  32'h55AA55AA, 20'd524288, 20'd1);
      queue_roll(10'd1,    32'h00000001, 20'd1000000, 20'd999999);
      queue_roll(10'd341,  32'hAAAAAAAA, 20'd349525, 20'd699050);
      queue_roll(10'd682,  32'h55555555, 20'd699050, 20'd349525);
      queue_roll(10'd100,  32'h12345678, 20'd4242,   20'd1000001);

      random_phase(32'hFFFFFFFF);
      random_phase($urandom);
      random_phase(32'h00000000);
      random_phase(32'h80000001);
      random_phase($urandom);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      mismatches += expected_hits.size();
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/hcr_pkg.sv
rtl/core/hcr_if.sv
rtl/core/hcr_mix.sv
rtl/core/hcr_mod.sv
rtl/core/hashed_chance_roll_unit.sv
verif/tb_hashed_chance_roll_unit.sv
